/* design/dpe_pkg.sv */
package dpe_pkg;

    localparam int VALUE_W          = 32;
    localparam int MAX_ELEMENTS_DEF = 8;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } dpe_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] low_value;
        logic signed [VALUE_W-1:0] high_value;
        logic                      last_pair;
        logic                      no_pairs;
        logic                      overflow;
    } dpe_out_t;

endpackage

/* design/distinct_pair_enumerator.sv */
// An input word is taken in ST_IDLE, then its insertion scan in ST_SCAN steps past each
// stored value smaller than it (at most MAX_ELEMENTS of them).
// The next word waits until this scan ends; the shared compare unit walks the store.
// On the last word, results follow one per cycle when not stalled, after a fetch step per row.
// Reset (aresetn low, synchronous) clears the sequencer, the count, the overflow flag and
// the result valid; the value store itself is not reset and is only read below the count.
module distinct_pair_enumerator #(
    parameter int MAX_ELEMENTS = dpe_pkg::MAX_ELEMENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dpe_pkg::dpe_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dpe_pkg::dpe_out_t m_data
);
    import dpe_pkg::*;

    // Index width covers the store depth; count width can also hold the depth itself.
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_ROW    = 3'd2;
    localparam logic [2:0] ST_PAIR   = 3'd3;
    localparam logic [2:0] ST_NOPAIR = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic signed [VALUE_W-1:0] store_reg [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] store_next [MAX_ELEMENTS];
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          row_reg, row_next;
    logic [CNT_W-1:0]          col_reg, col_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      last_reg, last_next;
    logic signed [VALUE_W-1:0] low_reg, low_next;
    logic                      m_valid_reg, m_valid_next;
    dpe_out_t                  m_data_reg, m_data_next;

    // The single store read port, shared by the scan, the row fetch and the pair fetch.
    logic [CNT_W-1:0]          rd_sel;
    logic signed [VALUE_W-1:0] rd_data;
    // The shared comparator results.
    logic                      in_range;
    logic                      is_less;
    logic                      is_equal;
    logic                      do_insert;
    logic                      out_free;
    logic                      row_done;
    logic                      set_done;

    always_comb begin
        unique case (state_reg)
            ST_ROW:  rd_sel = row_reg;
            ST_PAIR: rd_sel = col_reg;
            default: rd_sel = idx_reg;
        endcase
        if (rd_sel < CNT_W'(MAX_ELEMENTS)) begin
            rd_data = store_reg[rd_sel[IDX_W-1:0]];
        end else begin
            rd_data = '0;
        end
    end

    assign in_range = idx_reg < count_reg;
    assign is_less  = rd_data < val_reg;
    assign is_equal = rd_data == val_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign row_done = col_reg == count_reg - CNT_W'(1);
    assign set_done = row_reg == count_reg - CNT_W'(2);

    // Insertion happens at the end of the scan when the value is new and the store has room.
    assign do_insert = (state_reg == ST_SCAN) && !(in_range && is_less)
                       && !(in_range && is_equal)
                       && (count_reg < CNT_W'(MAX_ELEMENTS));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        val_next     = val_reg;
        last_next    = last_reg;
        low_next     = low_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // Shift the entries above the insertion point up by one and drop the new value in.
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            store_next[k] = store_reg[k];
            if (do_insert) begin
                if (CNT_W'(k) == idx_reg) begin
                    store_next[k] = val_reg;
                end else if (CNT_W'(k) > idx_reg && CNT_W'(k) <= count_reg) begin
                    store_next[k] = store_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next   = s_data.value;
                    last_next  = s_data.last;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (in_range && is_less) begin
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    if (do_insert) begin
                        count_next = count_reg + CNT_W'(1);
                    end else if (!(in_range && is_equal)) begin
                        dropped_next = 1'b1;
                    end
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (count_next < CNT_W'(2)) begin
                        state_next = ST_NOPAIR;
                    end else begin
                        row_next   = '0;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                low_next   = rd_data;
                col_next   = row_reg + CNT_W'(1);
                state_next = ST_PAIR;
            end
            ST_PAIR: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.low_value  = low_reg;
                    m_data_next.high_value = rd_data;
                    m_data_next.last_pair  = row_done && set_done;
                    m_data_next.no_pairs   = 1'b0;
                    m_data_next.overflow   = dropped_reg;
                    if (!row_done) begin
                        col_next = col_reg + CNT_W'(1);
                    end else if (set_done) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        row_next   = row_reg + CNT_W'(1);
                        state_next = ST_ROW;
                    end
                end
            end
            ST_NOPAIR: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.low_value  = '0;
                    m_data_next.high_value = '0;
                    m_data_next.last_pair  = 1'b1;
                    m_data_next.no_pairs   = 1'b1;
                    m_data_next.overflow   = dropped_reg;
                    count_next             = '0;
                    dropped_next           = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        store_reg  <= store_next;
        idx_reg    <= idx_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
        low_reg    <= low_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The count never runs past the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("distinct count exceeds store depth");

    // The two lowest stored values are strictly ascending whenever both exist.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> store_reg[0] < store_reg[1])
        else $error("store lost its ascending order");

    // While pairs are emitted, the column index stays above the row and inside the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PAIR |-> (col_reg > row_reg) && (col_reg < count_reg))
        else $error("pair indexes out of order");

    // A no-pairs result always closes its set and carries zero values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.no_pairs |->
            m_data_reg.last_pair && (m_data_reg.low_value == '0)
            && (m_data_reg.high_value == '0))
        else $error("malformed no-pairs result");

endmodule
